>>> src/ffsa_pkg.sv
// Shared types and constants for the first-fit segment allocator
package ffsa_pkg;
    localparam int MAX_SEGMENTS = 16;
    localparam int ADDR_WIDTH   = 16;
    localparam int OWNER_WIDTH  = 8;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam logic [ADDR_WIDTH-1:0] HEAP_RESET = 16'd1024;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [0:0] REG_HEAP_SIZE = 1'b0;

    typedef struct packed {
        logic                  mode;
        logic [OWNER_WIDTH-1:0] owner_id;
        logic [ADDR_WIDTH-1:0] request_size;
        logic [ADDR_WIDTH-1:0] start_index;
    } req_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, clear scan index
        logic step;      // advance scan index
        logic alloc_hit; // apply allocate at scan index
        logic free_hit;  // apply free at scan index
        logic init;      // reinitialize table
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic at_end;    // scan index reached segment count
        logic alloc_ok;  // current entry fits request
        logic free_ok;   // current entry matches free target
        logic exact;     // fit is exact
        logic full;      // table full
        logic zero_req;  // zero-size allocate
        logic mode;
    } dp_stat_t;
endpackage

>>> src/ffsa_if.sv
// Valid/ready channel interfaces
interface ffsa_req_if;
    logic             valid;
    logic             ready;
    ffsa_pkg::req_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffsa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [ffsa_pkg::ADDR_WIDTH-1:0]   alloc_start;
    modport source (output valid, output status, output alloc_start, input ready);
    modport sink   (input valid, input status, input alloc_start, output ready);
endinterface

>>> src/ffsa_datapath.sv
// Segment table, scan index and split/merge shifting
module ffsa_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ffsa_pkg::dp_cmd_t               cmd,
    input  ffsa_pkg::req_t                  req,
    input  logic [ffsa_pkg::ADDR_WIDTH-1:0] heap_size,
    output ffsa_pkg::dp_stat_t              stat,
    output logic [ffsa_pkg::ADDR_WIDTH-1:0] cur_start
);
    localparam int N  = ffsa_pkg::MAX_SEGMENTS;
    localparam int AW = ffsa_pkg::ADDR_WIDTH;
    localparam int OW = ffsa_pkg::OWNER_WIDTH;
    localparam int IW = ffsa_pkg::IDX_W;
    localparam int CW = ffsa_pkg::CNT_W;

    logic [AW-1:0] start_reg  [N];
    logic [AW-1:0] length_reg [N];
    logic          free_reg   [N];
    logic [OW-1:0] owner_reg  [N];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    ffsa_pkg::req_t req_reg;

    logic [IW-1:0] ix;
    logic          has_next;
    logic          has_prev;
    logic          next_free;
    logic          prev_free;

    assign ix        = idx_reg[IW-1:0];
    assign has_next  = ({1'b0, idx_reg} + 1'b1) < {1'b0, count_reg};
    assign has_prev  = idx_reg != '0;
    assign next_free = has_next && free_reg[IW'(ix + 1'b1)];
    assign prev_free = has_prev && free_reg[IW'(ix - 1'b1)];
    assign cur_start = start_reg[ix];

    always_comb
    begin
        stat.at_end   = idx_reg >= count_reg;
        stat.alloc_ok = free_reg[ix] && length_reg[ix] >= req_reg.request_size;
        stat.free_ok  = !free_reg[ix] && owner_reg[ix] == req_reg.owner_id
                        && start_reg[ix] == req_reg.start_index;
        stat.exact    = length_reg[ix] == req_reg.request_size;
        stat.full     = count_reg == CW'(N);
        stat.zero_req = req_reg.request_size == '0;
        stat.mode     = req_reg.mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(1);
            idx_reg   <= '0;
        end
        else if (cmd.init)
        begin
            count_reg <= CW'(1);
        end
        else if (cmd.load)
        begin
            idx_reg <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        else if (cmd.alloc_hit && !stat.exact)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (cmd.free_hit)
        begin
            count_reg <= count_reg - CW'(next_free) - CW'(prev_free);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
    end

    // Table: entry 0 reset via asynchronous reset; others written before read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg[0]  <= '0;
            length_reg[0] <= ffsa_pkg::HEAP_RESET;
            free_reg[0]   <= 1'b1;
        end
        else if (cmd.init)
        begin
            start_reg[0]  <= '0;
            length_reg[0] <= heap_size;
            free_reg[0]   <= 1'b1;
        end
        else if (cmd.alloc_hit)
        begin
            free_reg[ix]  <= 1'b0;
            owner_reg[ix] <= req_reg.owner_id;
            if (!stat.exact)
            begin
                length_reg[ix] <= req_reg.request_size;
                for (int j = 1; j < N; j++)
                begin
                    if (IW'(j) == IW'(ix + 1'b1))
                    begin
                        start_reg[j]  <= start_reg[ix] + req_reg.request_size;
                        length_reg[j] <= length_reg[ix] - req_reg.request_size;
                        free_reg[j]   <= 1'b1;
                        owner_reg[j]  <= '0;
                    end
                    else if (IW'(j) > IW'(ix + 1'b1))
                    begin
                        start_reg[j]  <= start_reg[j-1];
                        length_reg[j] <= length_reg[j-1];
                        free_reg[j]   <= free_reg[j-1];
                        owner_reg[j]  <= owner_reg[j-1];
                    end
                end
            end
        end
        else if (cmd.free_hit)
        begin
            // merged entry lands at ix-1 (prev free) or ix; drop 0..2 slots
            for (int j = 0; j < N; j++)
            begin
                if (prev_free && IW'(j) == IW'(ix - 1'b1))
                begin
                    length_reg[j] <= length_reg[j] + length_reg[ix]
                                     + (next_free ? length_reg[IW'(ix + 1'b1)] : '0);
                end
                else if (!prev_free && IW'(j) == ix)
                begin
                    free_reg[j] <= 1'b1;
                    if (next_free)
                        length_reg[j] <= length_reg[ix] + length_reg[IW'(ix + 1'b1)];
                end
                else if (j > 0 && IW'(j) >= ix)
                begin
                    if (prev_free && next_free && j + 2 < N)
                    begin
                        start_reg[j]  <= start_reg[j+2];
                        length_reg[j] <= length_reg[j+2];
                        free_reg[j]   <= free_reg[j+2];
                        owner_reg[j]  <= owner_reg[j+2];
                    end
                    else if ((prev_free ^ next_free) && j + 1 < N
                             && (prev_free || IW'(j) > ix))
                    begin
                        start_reg[j]  <= start_reg[j+1];
                        length_reg[j] <= length_reg[j+1];
                        free_reg[j]   <= free_reg[j+1];
                        owner_reg[j]  <= owner_reg[j+1];
                    end
                end
            end
        end
    end
endmodule

>>> src/ffsa_ctrl.sv
// Request sequencer: scan, apply, respond
module ffsa_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [ffsa_pkg::ADDR_WIDTH-1:0] alloc_start,
    input  logic                            cfg_write,
    input  ffsa_pkg::dp_stat_t              stat,
    input  logic [ffsa_pkg::ADDR_WIDTH-1:0] cur_start,
    output ffsa_pkg::dp_cmd_t               cmd
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg;
    logic [1:0] status_reg;
    logic [ffsa_pkg::ADDR_WIDTH-1:0] astart_reg;
    logic   done;
    logic [1:0] st_val;
    logic [ffsa_pkg::ADDR_WIDTH-1:0] as_val;

    assign in_ready    = state_reg == S_IDLE;
    assign out_valid   = ovalid_reg;
    assign status      = status_reg;
    assign alloc_start = astart_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done       = 1'b0;
        st_val     = ffsa_pkg::ST_NO_FIT;
        as_val     = '0;
        cmd.init   = cfg_write;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.mode == ffsa_pkg::MODE_ALLOC)
                begin
                    if (stat.zero_req || stat.at_end)
                        done = 1'b1;
                    else if (stat.alloc_ok)
                    begin
                        done = 1'b1;
                        if (!stat.exact && stat.full)
                            st_val = ffsa_pkg::ST_FULL;
                        else
                        begin
                            cmd.alloc_hit = 1'b1;
                            st_val        = ffsa_pkg::ST_OK;
                            as_val        = cur_start;
                        end
                    end
                    else
                        cmd.step = 1'b1;
                end
                else
                begin
                    st_val = ffsa_pkg::ST_NOT_FOUND;
                    if (stat.at_end)
                        done = 1'b1;
                    else if (stat.free_ok)
                    begin
                        done         = 1'b1;
                        cmd.free_hit = 1'b1;
                        st_val       = ffsa_pkg::ST_OK;
                    end
                    else
                        cmd.step = 1'b1;
                end
                if (done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!ovalid_reg)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            status_reg <= st_val;
            astart_reg <= as_val;
        end
    end
endmodule

>>> src/first_fit_segment_allocator.sv
// Top level: first-fit segment allocator with coalescing
// Usage:
//   req channel carries mode (0 allocate, 1 free), owner_id, request_size
//   and start_index; rsp channel returns status and alloc_start, one
//   transaction per request, in order.
//   heap_size is written over the APB port at address 0; a write resets the
//   table to one free segment. Write it only while the block is idle.
// Operation:
//   A request is taken while the sequencer is idle, then the table is scanned one entry
//   per cycle until the first match; the split or merge is applied and the
//   result registered at the edge of the hit, and rsp.valid is set at that
//   same edge. A new request is taken only after the previous response
//   has been delivered and the sequencer has returned to idle.
// Reset: table holds one free segment of 1024 units; channels idle.
// Stall: the result is held in its output register while rsp.ready is low;
//   no new request is taken until it has been delivered.
module first_fit_segment_allocator (
    input  logic        clk,
    input  logic        rst_n,
    ffsa_req_if.sink    req,
    ffsa_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    ffsa_pkg::dp_cmd_t  cmd;
    ffsa_pkg::dp_stat_t stat;
    logic [ffsa_pkg::ADDR_WIDTH-1:0] cur_start;
    logic [ffsa_pkg::ADDR_WIDTH-1:0] heap_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && paddr[1:0] == 2'(ffsa_pkg::REG_HEAP_SIZE);
    assign prdata    = (paddr[1:0] == 2'(ffsa_pkg::REG_HEAP_SIZE))
                       ? 32'(heap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heap_reg <= ffsa_pkg::HEAP_RESET;
        else if (cfg_write)
            heap_reg <= pwdata[ffsa_pkg::ADDR_WIDTH-1:0];
    end

    ffsa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .status      (rsp.status),
        .alloc_start (rsp.alloc_start),
        .cfg_write   (cfg_write),
        .stat        (stat),
        .cur_start   (cur_start),
        .cmd         (cmd)
    );

    ffsa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req.data),
        .heap_size (pwdata[ffsa_pkg::ADDR_WIDTH-1:0]),
        .stat      (stat),
        .cur_start (cur_start)
    );
endmodule
